// File: rtl/rgbenc_pkg.sv
`timescale 1ns / 1ps

package rgbenc_pkg;

	// Colour word and serial framing
	localparam int PIXEL_W     = 24;
	localparam int WORD_BITS   = 24;
	localparam int BIT_IDX_W   = $clog2(WORD_BITS);

	// Configuration register widths and port shape
	localparam int TICK_W      = 8;
	localparam int GAP_W       = 16;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;

	// Stream payload widths (whole bytes)
	localparam int S_TDATA_W   = 24;
	localparam int M_TDATA_W   = 8;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BIT_PERIOD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GAP        = 2'd3;

	// Reset values of the configuration registers
	localparam logic [TICK_W-1:0] BIT_PERIOD_RST = 8'd25;
	localparam logic [TICK_W-1:0] ZERO_HIGH_RST  = 8'd8;
	localparam logic [TICK_W-1:0] ONE_HIGH_RST   = 8'd16;
	localparam logic [GAP_W-1:0]  GAP_RST        = 16'd1200;

endpackage

// File: rtl/rgb_led_serial_line_encoder.sv
`timescale 1ns / 1ps

// RGB LED serial line encoder: one-wire NRZ timing for chained RGB LEDs.
// Input stream (s_axis_*): one item per tick of the prescaled bit clock.
//   tuser marks that the item offers a colour word, tdata carries the word
//   (first colour byte in bits 23..16), tlast marks the frame's final word.
//   A word offered while the one-word holding buffer is full is dropped.
// Output stream (m_axis_*): one item per input item, giving the line level,
//   whether the holding buffer is free, and (on tlast) the frame-done pulse.
// Words go out MSB first; each bit period is high for the zero or one high
//   time, then low. A low gap of gap_ticks precedes every frame.
// Path: an accepted item goes through the input register, then the result
//   register, to m_axis. Throughput: one item per cycle while m_axis_tready
//   is high; the whole tick update is a single pass of counter/compare logic.
// Stall: when m_axis_tready is low the result register holds and the input
//   register fills, then s_axis_tready drops; the encoder state only advances
//   when an item moves into the result register, so no tick is lost.
// Reset (arst_n low): encoder idle, buffer empty, timing registers back to
//   25/8/16/1200 ticks. Write config (cfg_we) only while no item is in flight.
module rgb_led_serial_line_encoder (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// configuration write port
	input  logic                                  cfg_we,
	input  logic [rgbenc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [rgbenc_pkg::CFG_DATA_W-1:0]     cfg_data,
	// input stream
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  logic [rgbenc_pkg::S_TDATA_W-1:0]      s_axis_tdata,  // [23:0] pixel_word
	input  logic                                  s_axis_tuser,  // [0] word_valid
	input  logic                                  s_axis_tlast,  // last_of_frame
	// output stream
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	output logic [rgbenc_pkg::M_TDATA_W-1:0]      m_axis_tdata,  // [0] line_level,
	                                                             // [1] buffer_free,
	                                                             // [2] busy_res, rest 0
	output logic                                  m_axis_tlast   // frame_done
);
	import rgbenc_pkg::*;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_GAP  = 2'd1,
		PH_SEND = 2'd2
	} phase_t;

	// configuration
	logic [TICK_W-1:0]    bit_period_q, zero_high_q, one_high_q;
	logic [GAP_W-1:0]     gap_ticks_q;

	// input register
	logic                 valid_s1;
	logic                 word_valid_s1;
	logic [PIXEL_W-1:0]   pixel_s1;
	logic                 last_s1;

	// encoder state
	phase_t               phase_q;
	logic [PIXEL_W-1:0]   shift_word_q;
	logic [BIT_IDX_W-1:0] bit_index_q;
	logic [TICK_W-1:0]    tick_in_bit_q;
	logic [GAP_W-1:0]     gap_count_q;
	logic [PIXEL_W-1:0]   hold_word_q;
	logic                 hold_valid_q;
	logic                 hold_last_q;
	logic                 current_last_q;

	// result register
	logic                 out_valid_q;
	logic                 line_q, free_q, done_q, busy_q;

	// next-state logic
	logic                 advance;
	phase_t               n_phase;
	logic [PIXEL_W-1:0]   n_shift, n_hold_word;
	logic [BIT_IDX_W-1:0] n_bit_index;
	logic [TICK_W-1:0]    n_tick;
	logic [GAP_W-1:0]     n_gap;
	logic                 n_hold_valid, n_hold_last, n_cur_last;
	logic                 n_line, n_done, n_busy;
	logic                 do_load, do_send;
	logic [BIT_IDX_W-1:0] pos;
	logic                 bit_val;
	logic [TICK_W-1:0]    high_ticks;
	logic                 end_of_bit, end_of_word;

	// result register frees when empty or taken; input register then drains
	assign advance       = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;

	always_comb begin
		n_phase      = phase_q;
		n_shift      = shift_word_q;
		n_bit_index  = bit_index_q;
		n_tick       = tick_in_bit_q;
		n_gap        = gap_count_q;
		n_hold_word  = hold_word_q;
		n_hold_valid = hold_valid_q;
		n_hold_last  = hold_last_q;
		n_cur_last   = current_last_q;
		n_line       = 1'b0;
		n_done       = 1'b0;
		n_busy       = 1'b0;
		do_load      = 1'b0;
		do_send      = 1'b0;
		pos          = '0;
		bit_val      = 1'b0;
		high_ticks   = '0;
		end_of_bit   = 1'b0;
		end_of_word  = 1'b0;

		// latch an offered word into the holding buffer when it is free
		if (word_valid_s1 && !hold_valid_q) begin
			n_hold_word  = pixel_s1;
			n_hold_last  = last_s1;
			n_hold_valid = 1'b1;
		end

		case (phase_q)
			PH_SEND: begin
				n_busy  = 1'b1;
				do_send = 1'b1;
			end
			PH_GAP: begin
				n_busy = 1'b1;
				if (gap_count_q == '0) begin
					do_load = 1'b1;
					do_send = 1'b1;
				end else begin
					n_gap = gap_count_q - 1'b1;
				end
			end
			default: begin
				// idle; the tick that sees a held word is the first gap tick unless gap_ticks is 0
				n_phase = PH_IDLE;
				if (n_hold_valid) begin
					n_busy = 1'b1;
					if (gap_ticks_q == '0) begin
						do_load = 1'b1;
						do_send = 1'b1;
					end else begin
						n_gap   = gap_ticks_q - 1'b1;
						n_phase = PH_GAP;
					end
				end
			end
		endcase

		if (do_load) begin
			n_shift      = n_hold_word;
			n_cur_last   = n_hold_last;
			n_hold_valid = 1'b0;
			n_bit_index  = '0;
			n_tick       = '0;
			n_phase      = PH_SEND;
		end

		if (do_send) begin
			pos = BIT_IDX_W'(WORD_BITS - 1) - n_bit_index;
			// positions beyond the colour word send as zero
			if ({1'b0, pos} < (BIT_IDX_W + 1)'(PIXEL_W))
				bit_val = n_shift[pos];
			high_ticks  = bit_val ? one_high_q : zero_high_q;
			n_line      = (n_tick < high_ticks);
			end_of_bit  = ({1'b0, n_tick} + 1'b1) >= {1'b0, bit_period_q};
			end_of_word = ({1'b0, n_bit_index} + 1'b1) >= (BIT_IDX_W + 1)'(WORD_BITS);
			if (end_of_bit) begin
				n_tick = '0;
				if (end_of_word) begin
					n_bit_index = '0;
					if (n_cur_last) begin
						n_done     = 1'b1;
						n_cur_last = 1'b0;
						n_phase    = PH_IDLE;
					end else if (n_hold_valid) begin
						// back-to-back word, no gap
						n_shift      = n_hold_word;
						n_cur_last   = n_hold_last;
						n_hold_valid = 1'b0;
						n_phase      = PH_SEND;
					end else begin
						// underrun: drop back to idle without a frame end
						n_phase = PH_IDLE;
					end
				end else begin
					n_bit_index = n_bit_index + 1'b1;
				end
			end else begin
				n_tick = n_tick + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_period_q   <= BIT_PERIOD_RST;
			zero_high_q    <= ZERO_HIGH_RST;
			one_high_q     <= ONE_HIGH_RST;
			gap_ticks_q    <= GAP_RST;
			valid_s1       <= 1'b0;
			word_valid_s1  <= 1'b0;
			last_s1        <= 1'b0;
			phase_q        <= PH_IDLE;
			shift_word_q   <= '0;
			bit_index_q    <= '0;
			tick_in_bit_q  <= '0;
			gap_count_q    <= '0;
			hold_valid_q   <= 1'b0;
			hold_last_q    <= 1'b0;
			current_last_q <= 1'b0;
			out_valid_q    <= 1'b0;
			line_q         <= 1'b0;
			free_q         <= 1'b0;
			done_q         <= 1'b0;
			busy_q         <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_BIT_PERIOD: bit_period_q <= cfg_data[TICK_W-1:0];
					REG_ZERO_HIGH:  zero_high_q  <= cfg_data[TICK_W-1:0];
					REG_ONE_HIGH:   one_high_q   <= cfg_data[TICK_W-1:0];
					REG_GAP:        gap_ticks_q  <= cfg_data[GAP_W-1:0];
					default:        ;
				endcase
			end

			// input register
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
				if (s_axis_tvalid) begin
					word_valid_s1 <= s_axis_tuser;
					last_s1       <= s_axis_tlast;
				end
			end

			// one tick of the encoder per item moved into the result register
			if (advance) begin
				out_valid_q <= valid_s1;
				if (valid_s1) begin
					phase_q        <= n_phase;
					shift_word_q   <= n_shift;
					bit_index_q    <= n_bit_index;
					tick_in_bit_q  <= n_tick;
					gap_count_q    <= n_gap;
					hold_valid_q   <= n_hold_valid;
					hold_last_q    <= n_hold_last;
					current_last_q <= n_cur_last;
					line_q         <= n_line;
					free_q         <= !n_hold_valid;
					done_q         <= n_done;
					busy_q         <= n_busy;
				end
			end
		end
	end

	// payload registers without reset
	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid)
			pixel_s1 <= s_axis_tdata[PIXEL_W-1:0];
		if (advance && valid_s1)
			hold_word_q <= n_hold_word;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(M_TDATA_W - 3){1'b0}}, busy_q, free_q, line_q};
	assign m_axis_tlast  = done_q;

	// a frame end or a high line only happens on a busy tick
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && done_q |-> busy_q)
		else $error("frame_done without busy");

	a_line_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && line_q |-> busy_q)
		else $error("line high while not busy");

	// a gap is only entered with a word waiting in the holding buffer
	a_gap_held: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_GAP |-> hold_valid_q)
		else $error("gap phase with empty holding buffer");

	// an empty result register never blocks the input side
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> s_axis_tready)
		else $error("input stalled with empty result register");

endmodule
